### hdl/usan_pkg.sv
// Shared types, constants and the lead byte decoder of the UTF-8 stream sanitizer.
package usan_pkg;

	localparam int SLOT_MAX = 6;
	localparam int CNT_W    = 3;

	typedef logic [7:0]       byte_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam byte_t REPL_RESET = 8'h20;
	localparam cnt_t  LEN_BAD    = 3'd0;
	localparam cnt_t  LEN_ASCII  = 3'd1;

	typedef struct packed {
		byte_t [SLOT_MAX-1:0] data;
		logic  [SLOT_MAX-1:0] repl;
		cnt_t                 len;
	} cmd_t;

	function automatic cnt_t seq_length(input byte_t b, input cnt_t max_len);
		cnt_t len;
		if (b[7] == 1'b0) begin
			len = LEN_ASCII;
		end else if (b[6] == 1'b0) begin
			len = LEN_BAD;
		end else if (b[5] == 1'b0) begin
			len = 3'd2;
		end else if (b[4] == 1'b0) begin
			len = 3'd3;
		end else if (b[3] == 1'b0) begin
			len = 3'd4;
		end else if (b[2] == 1'b0) begin
			len = 3'd5;
		end else if (b[1] == 1'b0) begin
			len = 3'd6;
		end else begin
			len = LEN_BAD;
		end
		if (len > max_len) begin
			len = LEN_BAD;
		end
		return len;
	endfunction

endpackage

### hdl/usan_if.sv
// Valid/ready channel interfaces for input words and result words.
interface usan_in_if;
	logic              valid;
	logic              ready;
	usan_pkg::byte_t   data_byte;
	logic              end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface usan_out_if;
	logic              valid;
	logic              ready;
	usan_pkg::byte_t   out_byte;
	logic              was_replaced;
	logic              last_of_run;

	modport source (output valid, output out_byte, output was_replaced, output last_of_run,
		input ready);
	modport sink (input valid, input out_byte, input was_replaced, input last_of_run,
		output ready);
endinterface

### hdl/usan_front.sv
// Front end: accept input words, track the open sequence and build emit commands.
module usan_front #(
	parameter int MAX_SEQ_LEN = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	usan_in_if.sink         in_ch,
	output logic            cmd_push,
	output usan_pkg::cmd_t  cmd,
	input  logic            cmd_ready
);

	localparam usan_pkg::cnt_t MAX_CNT = usan_pkg::CNT_W'(MAX_SEQ_LEN);

	usan_pkg::byte_t held_q [MAX_SEQ_LEN-1];
	usan_pkg::cnt_t  cnt_q, cnt_d;
	usan_pkg::cnt_t  exp_q, exp_d;
	usan_pkg::cnt_t  len;
	usan_pkg::cnt_t  grown;
	logic            absorb;
	logic            store_lead;
	logic            store_cont;
	logic            accept;
	usan_pkg::byte_t b;
	logic            eos;

	assign b      = in_ch.data_byte;
	assign eos    = in_ch.end_of_stream;
	assign accept = in_ch.valid && cmd_ready;
	assign in_ch.ready = cmd_ready;

	assign len    = usan_pkg::seq_length(b, MAX_CNT);
	assign grown  = cnt_q + 1'b1;
	assign absorb = (cnt_q != '0) && (b[7:6] == 2'b10) && (cnt_q < MAX_CNT);

	always_comb begin
		cmd        = '0;
		cnt_d      = cnt_q;
		exp_d      = exp_q;
		store_lead = 1'b0;
		store_cont = 1'b0;
		if (absorb) begin
			if (grown >= exp_q) begin
				for (int i = 0; i < MAX_SEQ_LEN - 1; i++) begin
					cmd.data[i] = held_q[i];
				end
				for (int i = 0; i < usan_pkg::SLOT_MAX; i++) begin
					if (usan_pkg::CNT_W'(i) == cnt_q) begin
						cmd.data[i] = b;
					end
				end
				cmd.len = grown;
				cnt_d   = '0;
				exp_d   = '0;
			end else if (eos) begin
				for (int i = 0; i < usan_pkg::SLOT_MAX; i++) begin
					cmd.repl[i] = usan_pkg::CNT_W'(i) < grown;
				end
				cmd.len = grown;
				cnt_d   = '0;
				exp_d   = '0;
			end else begin
				store_cont = 1'b1;
				cnt_d      = grown;
			end
		end else begin
			for (int i = 0; i < usan_pkg::SLOT_MAX; i++) begin
				cmd.repl[i] = usan_pkg::CNT_W'(i) < cnt_q;
			end
			cmd.len = cnt_q;
			cnt_d   = '0;
			exp_d   = '0;
			if (len == usan_pkg::LEN_ASCII) begin
				for (int i = 0; i < usan_pkg::SLOT_MAX; i++) begin
					if (usan_pkg::CNT_W'(i) == cnt_q) begin
						cmd.data[i] = b;
					end
				end
				cmd.len = grown;
			end else if (len == usan_pkg::LEN_BAD || eos) begin
				for (int i = 0; i < usan_pkg::SLOT_MAX; i++) begin
					if (usan_pkg::CNT_W'(i) == cnt_q) begin
						cmd.repl[i] = 1'b1;
					end
				end
				cmd.len = grown;
			end else begin
				store_lead = 1'b1;
				cnt_d      = 3'd1;
				exp_d      = len;
			end
		end
	end

	assign cmd_push = accept && (cmd.len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			exp_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			exp_q <= exp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_SEQ_LEN - 1; i++) begin
				if (store_lead && i == 0) begin
					held_q[i] <= b;
				end else if (store_cont && usan_pkg::CNT_W'(i) == cnt_q) begin
					held_q[i] <= b;
				end
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < MAX_CNT)
		else $error("held count reached sequence limit");

	a_exp_above_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> (exp_q > cnt_q) && (exp_q <= MAX_CNT))
		else $error("open sequence length inconsistent with held count");

endmodule

### hdl/usan_queue.sv
// Command queue between the front end and the emitter.
module usan_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  usan_pkg::cmd_t  din,
	output logic            ready,
	input  logic            pop,
	output usan_pkg::cmd_t  dout,
	output logic            valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	usan_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign ready   = cnt_q < CNT_W'(DEPTH);
	assign valid   = cnt_q != '0;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above depth");

endmodule

### hdl/usan_back.sv
// Emitter: step through one command a word per cycle onto the result channel while it is ready.
module usan_back (
	input  logic            clk,
	input  logic            arst_n,
	input  usan_pkg::byte_t repl_byte,
	input  logic            cmd_valid,
	input  usan_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	usan_out_if.source      out_ch
);

	usan_pkg::cmd_t cur_q;
	usan_pkg::cnt_t idx_q;
	logic           busy_q;
	logic           fire;
	logic           last;
	logic           load;

	assign fire    = out_ch.valid && out_ch.ready;
	assign last    = idx_q == (cur_q.len - 1'b1);
	assign load    = !busy_q || (fire && last);
	assign cmd_pop = load && cmd_valid;

	assign out_ch.valid        = busy_q;
	assign out_ch.was_replaced = cur_q.repl[idx_q];
	assign out_ch.out_byte     = cur_q.repl[idx_q] ? repl_byte : cur_q.data[idx_q];
	assign out_ch.last_of_run  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= cmd_valid;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd;
		end
	end

	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_q.len != '0) && (idx_q < cur_q.len))
		else $error("emit index outside current command");

endmodule

### hdl/utf8_stream_sanitizer_top.sv
// Top level of the UTF-8 stream sanitizer.
//
//  channel   dir   handshake              word
//  in_ch     in    valid/ready            data_byte[7:0], end_of_stream
//  out_ch    out   valid/ready            out_byte[7:0], was_replaced, last_of_run
//  cfg       in    cfg_wr_en, no ready    cfg_wr_data[7:0] -> replacement byte
//
// One input word is taken per cycle while the command queue has room.
// The emitter gives one result word per cycle while out_ch is ready; an input causes 0 to 6 of them.
// Input rate is bound by result rate, buffered by QUEUE_DEPTH commands.
// Reset empties the queue, drops the open sequence and sets the replacement to a space.
// An output stall holds the current word and backs up into the queue, then the input.
module utf8_stream_sanitizer_top #(
	parameter int MAX_SEQ_LEN = 6,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	usan_in_if.sink         in_ch,
	usan_out_if.source      out_ch,
	input  logic            cfg_wr_en,
	input  usan_pkg::byte_t cfg_wr_data
);

	usan_pkg::byte_t repl_q;
	usan_pkg::cmd_t  push_cmd;
	usan_pkg::cmd_t  pop_cmd;
	logic            push;
	logic            q_ready;
	logic            q_valid;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= usan_pkg::REPL_RESET;
		end else if (cfg_wr_en) begin
			repl_q <= cfg_wr_data;
		end
	end

	usan_front #(
		.MAX_SEQ_LEN(MAX_SEQ_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cmd_push (push),
		.cmd      (push_cmd),
		.cmd_ready(q_ready)
	);

	usan_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_cmd),
		.ready (q_ready),
		.pop   (pop),
		.dout  (pop_cmd),
		.valid (q_valid)
	);

	usan_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.repl_byte(repl_q),
		.cmd_valid(q_valid),
		.cmd      (pop_cmd),
		.cmd_pop  (pop),
		.out_ch   (out_ch)
	);

endmodule
